@@ hw/rtl/tsb_pkg.sv @@
// ----------------------------------------------------------------------------
// tsb_pkg: texture sampler shared types and constants
// Item layouts, register codes and sizes used by the sampler modules.
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int MAX_DIM   = 64;
    localparam int FRAC_BITS = 12;
    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
    localparam int CRD_W     = $clog2(MAX_DIM);
    localparam int SIZE_W    = 7;
    localparam int COORD_W   = 20;
    localparam int RGB_W     = 24;
    localparam int PROD_W    = COORD_W + SIZE_W + 1;
    localparam int SC_W      = PROD_W - FRAC_BITS;
    localparam int MAG_W     = 14;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH   = 2'd0,
        REG_TEX_HEIGHT  = 2'd1,
        REG_WRAP_MODE   = 2'd2,
        REG_FILTER_MODE = 2'd3
    } tsb_reg_t;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [11:0]               texel_index;
        logic [RGB_W-1:0]          texel_rgb;
        logic signed [COORD_W-1:0] u_coord;
        logic signed [COORD_W-1:0] v_coord;
    } tsb_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } tsb_out_t;

    typedef struct packed {
        logic             we;
        logic [ADDR_W-1:0] waddr;
        logic [RGB_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } tsb_mem_req_t;

endpackage

@@ hw/rtl/tsb_rem.sv @@
// ----------------------------------------------------------------------------
// tsb_rem: iterative remainder unit
// Restoring remainder of a magnitude by the texture size, one bit a cycle.
// ----------------------------------------------------------------------------
module tsb_rem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tsb_pkg::MAG_W-1:0]  dividend,
    input  logic [tsb_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [tsb_pkg::SIZE_W-1:0] remainder
);
    import tsb_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MAG_W-1:0]    dvd_reg, dvd_next;
    logic [SIZE_W-1:0]   div_reg, div_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[MAG_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = SIZE_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[SIZE_W-1:0];
            dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/tsb_mem.sv @@
// ----------------------------------------------------------------------------
// tsb_mem: texel store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsb_mem (
    input  logic                      clk,
    input  tsb_pkg::tsb_mem_req_t     req,
    output logic [tsb_pkg::RGB_W-1:0] rdata
);
    import tsb_pkg::*;

    logic [RGB_W-1:0] store [MAX_DIM*MAX_DIM];
    logic [RGB_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            store[req.waddr] <= req.wdata;
        rdata_reg <= store[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/texture_sampler_bilinear_top.sv @@
// A write item is taken while idle. A sample runs through the 14-step remainder
// unit once per coordinate (two for nearest, four for bilinear), one store read
// per texel and six multiply-accumulate steps per channel; no new item is taken
// until its result is out, and a held result stalls the next one. Reset clears
// control and sets the registers to width and height 64, wrap on and nearest;
// the texel store is undefined until written.
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_top: nearest / bilinear RGB888 texture sampler
// Sequencer around a shared remainder unit, the texel store and one MAC.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  tsb_pkg::tsb_in_t               req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output tsb_pkg::tsb_out_t              rsp_data,
    input  logic                           cfg_we,
    input  logic [tsb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [tsb_pkg::SIZE_W-1:0]     cfg_wdata
);
    import tsb_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MULU  = 10'b0000000010,
        S_MULV  = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_MODGO = 10'b0000010000,
        S_MODWT = 10'b0000100000,
        S_READ  = 10'b0001000000,
        S_RDWT  = 10'b0010000000,
        S_BLEND = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    localparam logic [WGT_W-1:0] FX_ONE = WGT_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] FX_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    state_t state_reg, state_next;

    // configuration
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic              wrap_reg, filter_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;

    // sample working state
    tsb_in_t                  item_reg;
    logic signed [PROD_W-1:0] pu_reg, pv_reg;
    logic [FRAC_BITS-1:0]     fx_reg, fy_reg;
    logic signed [SC_W-1:0]   sc_reg [4];
    logic [CRD_W-1:0]         wc_reg [4];
    logic [3:0]               blk_reg;
    logic [1:0]               k_reg;          // coordinate under reduction
    logic [1:0]               j_reg;          // texel being read
    logic [RGB_W-1:0]         tex_reg [4];
    logic [2:0]               step_reg;
    logic [1:0]               ch_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [19:0]              top_reg, bot_reg;
    logic [7:0]               res_reg [3];
    logic                     rsp_valid_reg;
    tsb_out_t                 rsp_data_reg;

    // size multiply
    logic signed [COORD_W-1:0] mul_op;
    logic signed [PROD_W-1:0]  mul_p;

    // coordinate preparation
    logic                      pu_neg, pv_neg;
    logic [PROD_W-1:0]         pu_mag, pv_mag, pu_rnd, pv_rnd;
    logic signed [SC_W-1:0]    ru, rv, flu, flv;

    // remainder unit
    logic                      rem_start, rem_done;
    logic [SIZE_W-1:0]         rem_val, rem_size;
    logic signed [SC_W-1:0]    sc_cur;
    logic                      sc_neg;
    logic [SC_W-1:0]           sc_mag;
    logic [SIZE_W-1:0]         wrapped;
    logic                      blk_cur;

    // store access
    tsb_mem_req_t              mem_req;
    logic [RGB_W-1:0]          mem_rdata;
    logic [CRD_W-1:0]          rd_x, rd_y;
    logic                      rd_blk;
    logic [ADDR_W:0]           rd_addr;

    // blend MAC
    logic [7:0]                c00, c10, c01, c11;
    logic [19:0]               mac_a;
    logic [WGT_W-1:0]          mac_b;
    logic [WGT_W-1:0]          wx0, wy0;
    logic [ACC_W-1:0]          mac_p, mac_sum;

    assign w_eff = (width_reg == '0) ? SIZE_W'(1) :
                   (width_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : width_reg;
    assign h_eff = (height_reg == '0) ? SIZE_W'(1) :
                   (height_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : height_reg;

    assign req_ready = (state_reg == S_IDLE);

    // u*width or v*height, exact with FRAC_BITS fraction bits
    assign mul_op = (state_reg == S_MULU) ? item_reg.u_coord : item_reg.v_coord;
    assign mul_p  = PROD_W'(mul_op) *
                    PROD_W'($signed({1'b0, (state_reg == S_MULU) ? w_eff : h_eff}));

    // nearest: round half away from zero; linear: floor and fraction
    assign pu_neg = pu_reg[PROD_W-1];
    assign pv_neg = pv_reg[PROD_W-1];
    assign pu_mag = pu_neg ? PROD_W'(-pu_reg) : PROD_W'(pu_reg);
    assign pv_mag = pv_neg ? PROD_W'(-pv_reg) : PROD_W'(pv_reg);
    assign pu_rnd = (pu_mag + FX_HALF) >> FRAC_BITS;
    assign pv_rnd = (pv_mag + FX_HALF) >> FRAC_BITS;
    assign ru  = pu_neg ? -$signed(pu_rnd[SC_W-1:0]) : $signed(pu_rnd[SC_W-1:0]);
    assign rv  = pv_neg ? -$signed(pv_rnd[SC_W-1:0]) : $signed(pv_rnd[SC_W-1:0]);
    assign flu = pu_reg[PROD_W-1:FRAC_BITS];
    assign flv = pv_reg[PROD_W-1:FRAC_BITS];

    // coordinate reduction: remainder of the magnitude, then fold negatives
    assign sc_cur   = sc_reg[k_reg];
    assign sc_neg   = sc_cur[SC_W-1];
    assign sc_mag   = sc_neg ? SC_W'(-sc_cur) : SC_W'(sc_cur);
    assign rem_size = k_reg[1] ? h_eff : w_eff;
    assign rem_start = (state_reg == S_MODGO);
    assign wrapped  = (sc_neg && rem_val != '0) ? SIZE_W'(rem_size - rem_val) : rem_val;
    // nearest coordinates are reduced before the bounds check, so only a
    // negative non-zero remainder lies outside
    assign blk_cur  = !wrap_reg && (filter_reg ? (sc_neg || sc_mag >= SC_W'(rem_size))
                                               : (sc_neg && rem_val != '0));

    tsb_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (sc_mag[MAG_W-1:0]),
        .divisor   (rem_size),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // texel j: x from coordinate j[0], y from coordinate 2 + j[1]
    assign rd_x    = wc_reg[{1'b0, j_reg[0]}];
    assign rd_y    = wc_reg[{1'b1, j_reg[1]}];
    assign rd_blk  = blk_reg[{1'b0, j_reg[0]}] | blk_reg[{1'b1, j_reg[1]}];
    assign rd_addr = (ADDR_W + 1)'(rd_y * w_eff) + (ADDR_W + 1)'(rd_x);

    assign mem_req.we    = req_valid && req_ready && (req_data.req_type == REQ_WRITE);
    assign mem_req.waddr = req_data.texel_index;
    assign mem_req.wdata = req_data.texel_rgb;
    assign mem_req.raddr = rd_addr[ADDR_W-1:0];

    tsb_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // channel select: red, green, blue
    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                c00 = tex_reg[0][23:16]; c10 = tex_reg[1][23:16];
                c01 = tex_reg[2][23:16]; c11 = tex_reg[3][23:16];
            end
            2'd1:
            begin
                c00 = tex_reg[0][15:8]; c10 = tex_reg[1][15:8];
                c01 = tex_reg[2][15:8]; c11 = tex_reg[3][15:8];
            end
            default:
            begin
                c00 = tex_reg[0][7:0]; c10 = tex_reg[1][7:0];
                c01 = tex_reg[2][7:0]; c11 = tex_reg[3][7:0];
            end
        endcase
    end

    assign wx0 = FX_ONE - WGT_W'(fx_reg);
    assign wy0 = FX_ONE - WGT_W'(fy_reg);

    // even steps load the accumulator, odd steps add the second term
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mac_a = 20'(c00); mac_b = wx0; end
            3'd1:    begin mac_a = 20'(c10); mac_b = WGT_W'(fx_reg); end
            3'd2:    begin mac_a = 20'(c01); mac_b = wx0; end
            3'd3:    begin mac_a = 20'(c11); mac_b = WGT_W'(fx_reg); end
            3'd4:    begin mac_a = top_reg;  mac_b = wy0; end
            default: begin mac_a = bot_reg;  mac_b = WGT_W'(fy_reg); end
        endcase
    end

    assign mac_p   = ACC_W'(mac_a * mac_b);
    assign mac_sum = (step_reg[0] ? acc_reg : '0) + mac_p;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid && req_data.req_type == REQ_SAMPLE)
                    state_next = S_MULU;
            S_MULU:  state_next = S_MULV;
            S_MULV:  state_next = S_PREP;
            S_PREP:  state_next = S_MODGO;
            S_MODGO: state_next = S_MODWT;
            S_MODWT:
                if (rem_done)
                begin
                    if (k_reg == 2'd3 || (!filter_reg && k_reg == 2'd2))
                        state_next = S_READ;
                    else
                        state_next = S_MODGO;
                end
            S_READ:  state_next = S_RDWT;
            S_RDWT:
                if (!filter_reg)
                    state_next = S_OUT;
                else if (j_reg == 2'd3)
                    state_next = S_BLEND;
                else
                    state_next = S_READ;
            S_BLEND:
                if (step_reg == 3'd5 && ch_reg == 2'd2)
                    state_next = S_OUT;
            S_OUT:
                if (!rsp_valid_reg || rsp_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= SIZE_W'(64);
            height_reg    <= SIZE_W'(64);
            wrap_reg      <= 1'b1;
            filter_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            k_reg         <= '0;
            j_reg         <= '0;
            step_reg      <= '0;
            ch_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (tsb_reg_t'(cfg_addr))
                    REG_TEX_WIDTH:   width_reg  <= cfg_wdata;
                    REG_TEX_HEIGHT:  height_reg <= cfg_wdata;
                    REG_WRAP_MODE:   wrap_reg   <= cfg_wdata[0];
                    REG_FILTER_MODE: filter_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (state_reg == S_PREP)
                k_reg <= '0;
            else if (state_reg == S_MODWT && rem_done)
                k_reg <= filter_reg ? k_reg + 1'b1 : 2'd2;
            if (state_reg == S_PREP)
                j_reg <= '0;
            else if (state_reg == S_RDWT)
                j_reg <= j_reg + 1'b1;
            if (state_reg == S_PREP)
            begin
                step_reg <= '0;
                ch_reg   <= '0;
            end
            else if (state_reg == S_BLEND)
            begin
                if (step_reg == 3'd5)
                begin
                    step_reg <= '0;
                    ch_reg   <= ch_reg + 1'b1;
                end
                else
                    step_reg <= step_reg + 1'b1;
            end
            if (state_reg == S_OUT && (!rsp_valid_reg || rsp_ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
            item_reg <= req_data;
        if (state_reg == S_MULU)
            pu_reg <= mul_p;
        if (state_reg == S_MULV)
            pv_reg <= mul_p;
        if (state_reg == S_PREP)
        begin
            fx_reg <= pu_reg[FRAC_BITS-1:0];
            fy_reg <= pv_reg[FRAC_BITS-1:0];
            if (filter_reg)
            begin
                sc_reg[0] <= flu;
                sc_reg[1] <= flu + SC_W'(1);
                sc_reg[2] <= flv;
                sc_reg[3] <= flv + SC_W'(1);
            end
            else
            begin
                sc_reg[0] <= ru;
                sc_reg[1] <= ru;
                sc_reg[2] <= rv;
                sc_reg[3] <= rv;
            end
        end
        if (state_reg == S_MODWT && rem_done)
        begin
            wc_reg[k_reg]  <= wrapped[CRD_W-1:0];
            blk_reg[k_reg] <= blk_cur;
        end
        if (state_reg == S_RDWT)
            tex_reg[j_reg] <= rd_blk ? '0 : mem_rdata;
        if (state_reg == S_BLEND)
        begin
            acc_reg <= mac_sum;
            if (step_reg == 3'd1)
                top_reg <= mac_sum[19:0];
            if (step_reg == 3'd3)
                bot_reg <= mac_sum[19:0];
            if (step_reg == 3'd5)
                res_reg[ch_reg] <= mac_sum[2*FRAC_BITS+7:2*FRAC_BITS];
        end
        if (state_reg == S_OUT && (!rsp_valid_reg || rsp_ready))
        begin
            if (filter_reg)
            begin
                rsp_data_reg.red   <= res_reg[0];
                rsp_data_reg.green <= res_reg[1];
                rsp_data_reg.blue  <= res_reg[2];
            end
            else
            begin
                rsp_data_reg.red   <= tex_reg[0][23:16];
                rsp_data_reg.green <= tex_reg[0][15:8];
                rsp_data_reg.blue  <= tex_reg[0][7:0];
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
